>>> src/mpe_pkg.sv
package mpe_pkg;

    localparam int EXP_DEPTH_DEFAULT = 64;

    localparam logic [1:0] RULE_CONST = 2'd0;
    localparam logic [1:0] RULE_TEMP  = 2'd1;
    localparam logic [1:0] RULE_VISC  = 2'd2;
    localparam logic [1:0] RULE_NONE  = 2'd3;

    localparam logic [1:0] REG_RULE      = 2'd0;
    localparam logic [1:0] REG_PRIMARY   = 2'd1;
    localparam logic [1:0] REG_SECONDARY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SAT     = 2'd1;
    localparam logic [1:0] ST_ZERO_T  = 2'd2;
    localparam logic [1:0] ST_NO_RULE = 2'd3;

    localparam logic [16:0] FRAC_ONE = 17'd65536;
    localparam logic signed [16:0] T_REF = 17'sd4768;
    // 65536 * slope of primary, and slope difference primary - secondary
    localparam logic [43:0] W_BASE = 44'd5277655826432;
    localparam logic [21:0] SLOPE_DIFF = 22'd2684355;

    localparam logic signed [35:0] EXPA_CONST = -36'sd312039360;
    localparam logic [30:0]        EXPA_RECIP = 31'd1445274106;
    localparam logic signed [35:0] EXPB_CONST = -36'sd18641753;
    localparam logic [30:0]        EXPB_RECIP = 31'd1039253293;
    localparam logic [63:0]        LN2_Q32    = 64'd2977044472;

    // floor(n / 125) = floor(n * M125 / 2^39) for n below 2^32
    localparam logic [32:0] M125 = 33'd4398046512;
    localparam int          M125_SHIFT = 39;

    localparam int QUO_W = 33;
    localparam int DIV_BPS = 4;
    localparam int DIV_STAGES = (QUO_W + DIV_BPS - 1) / DIV_BPS;
    localparam int LIN_STAGES = 4;
    localparam int VIS_STAGES = 4;
    localparam int EXP_STAGES = 6;

    typedef struct packed {
        logic        use_visc;
        logic [16:0] y;
        logic [63:0] value;
        logic [1:0]  status;
    } mpe_side_t;

    function automatic logic [63:0] exp_series(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        logic        stop;
        sum  = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        stop = 1'b0;
        for (int n = 1; n <= 24; n++) begin
            if (!stop) begin
                term = ((term * x) >> 32) / 64'(n);
                if (term == '0)
                    stop = 1'b1;
                else
                    sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

>>> src/mixture_property_evaluator.sv
// Mixes a material property from a node's mass fraction and temperature under
// the configured rule and returns it in signed units of 2^-32 with a status.
// A request is taken on every cycle that start is high (busy stays low), and
// its result appears on prop_value and status with done high for one cycle;
// results come out in request order and cannot be held off. Each request
// passes through the four blend stages, the nine-stage 2^32/t reciprocal
// divider, four exponent blend stages, the six-stage table exponential and
// the output register, all in one chain. Configuration registers may be
// written only while no request is in flight.
module mixture_property_evaluator #(
    parameter int EXP_TABLE_DEPTH = mpe_pkg::EXP_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] mass_fraction,
    input  logic [15:0] temperature,
    output logic        done,
    output logic [63:0] prop_value,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import mpe_pkg::*;

    localparam int TAG_W = $bits(mpe_side_t);
    localparam int TOTAL_LAT = LIN_STAGES + DIV_STAGES + VIS_STAGES + EXP_STAGES + 1;

    logic [1:0]  rule_reg;
    logic [47:0] prim_reg;
    logic [47:0] sec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg <= RULE_CONST;
            prim_reg <= '0;
            sec_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RULE:      rule_reg <= cfg_data[1:0];
                REG_PRIMARY:   prim_reg <= cfg_data;
                REG_SECONDARY: sec_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic               lin_vld;
    logic [15:0]        lin_t;
    mpe_side_t          lin_side;

    mpe_linear u_linear (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .y         (mass_fraction),
        .t         (temperature),
        .rule      (rule_reg),
        .p         ($signed(prim_reg)),
        .s         ($signed(sec_reg)),
        .out_valid (lin_vld),
        .out_t     (lin_t),
        .out_side  (lin_side)
    );

    logic               div_vld;
    logic [QUO_W-1:0]   div_q;
    logic [TAG_W-1:0]   div_tag;
    mpe_side_t          div_side;

    mpe_recip #(
        .TAG_W (TAG_W)
    ) u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_vld),
        .t         (lin_t),
        .in_tag    (lin_side),
        .out_valid (div_vld),
        .quo       (div_q),
        .out_tag   (div_tag)
    );

    assign div_side = div_tag;

    // base-2 exponents of both components and their blend
    logic               v1_vld_reg, v2_vld_reg, v3_vld_reg, v4_vld_reg;
    mpe_side_t          v1_side_reg, v2_side_reg, v3_side_reg, v4_side_reg;
    logic [63:0]        v1_pa_reg, v1_pa_next;
    logic [63:0]        v1_pb_reg, v1_pb_next;
    logic signed [35:0] v2_a_reg, v2_a_next;
    logic signed [35:0] v2_b_reg, v2_b_next;
    logic signed [35:0] v3_a_reg;
    logic signed [54:0] v3_prod_reg, v3_prod_next;
    logic signed [39:0] v4_u_reg, v4_u_next;
    logic signed [36:0] ba;

    always_comb
    begin
        v1_pa_next = 64'(div_q) * 64'(EXPA_RECIP);
        v1_pb_next = 64'(div_q) * 64'(EXPB_RECIP);
        v2_a_next = $signed({2'b00, 34'((v1_pa_reg + 64'd536870912) >> 30)}) + EXPA_CONST;
        v2_b_next = $signed({2'b00, 34'((v1_pb_reg + 64'd536870912) >> 30)}) + EXPB_CONST;
        ba = 37'(v2_b_reg) - 37'(v2_a_reg);
        v3_prod_next = $signed({1'b0, v2_side_reg.y}) * ba;
        v4_u_next = 40'(v3_a_reg) + 40'((v3_prod_reg + 55'sd32768) >>> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_vld_reg <= 1'b0;
            v2_vld_reg <= 1'b0;
            v3_vld_reg <= 1'b0;
            v4_vld_reg <= 1'b0;
        end
        else
        begin
            v1_vld_reg <= div_vld;
            v2_vld_reg <= v1_vld_reg;
            v3_vld_reg <= v2_vld_reg;
            v4_vld_reg <= v3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_side_reg <= div_side;
        v1_pa_reg   <= v1_pa_next;
        v1_pb_reg   <= v1_pb_next;
        v2_side_reg <= v1_side_reg;
        v2_a_reg    <= v2_a_next;
        v2_b_reg    <= v2_b_next;
        v3_side_reg <= v2_side_reg;
        v3_a_reg    <= v2_a_reg;
        v3_prod_reg <= v3_prod_next;
        v4_side_reg <= v3_side_reg;
        v4_u_reg    <= v4_u_next;
    end

    logic               exp_vld;
    logic [31:0]        exp_res;
    logic [TAG_W-1:0]   exp_tag;
    mpe_side_t          exp_side;

    mpe_exp2 #(
        .DEPTH (EXP_TABLE_DEPTH),
        .TAG_W (TAG_W)
    ) u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_vld_reg),
        .u         (v4_u_reg),
        .in_tag    (v4_side_reg),
        .out_valid (exp_vld),
        .res       (exp_res),
        .out_tag   (exp_tag)
    );

    assign exp_side = exp_tag;

    logic        done_reg;
    logic [63:0] value_reg, value_next;
    logic [1:0]  status_reg;

    assign value_next = exp_side.use_visc ? {32'b0, exp_res} : exp_side.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= exp_vld;
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= exp_side.status;
    end

    assign done       = done_reg;
    assign prop_value = value_reg;
    assign status     = status_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##TOTAL_LAT done)
        else $error("request did not complete at fixed latency");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without request");

    a_no_rule_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_NO_RULE || status == ST_ZERO_T) |-> prop_value == '0)
        else $error("nonzero value with no-rule or zero-temperature status");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_SAT |->
            prop_value == 64'h7FFF_FFFF_FFFF_FFFF || prop_value == 64'h8000_0000_0000_0000)
        else $error("saturated status without limit value");

endmodule

>>> src/mpe_linear.sv
module mpe_linear
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [16:0]         y,
    input  logic [15:0]         t,
    input  logic [1:0]          rule,
    input  logic signed [47:0]  p,
    input  logic signed [47:0]  s,
    output logic                out_valid,
    output logic [15:0]         out_t,
    output mpe_pkg::mpe_side_t  out_side
);
    import mpe_pkg::*;

    // stage 1: products
    logic                l1_vld_reg;
    logic [16:0]         l1_y_reg;
    logic [15:0]         l1_t_reg;
    logic [1:0]          l1_rule_reg;
    logic signed [65:0]  l1_m0_reg, l1_m0_next;
    logic signed [65:0]  l1_m1_reg, l1_m1_next;
    logic [38:0]         l1_wy_reg, l1_wy_next;
    logic signed [16:0]  l1_d_reg, l1_d_next;
    logic [16:0]         y_c;
    logic [16:0]         y_m;

    always_comb
    begin
        y_c = (y > FRAC_ONE) ? FRAC_ONE : y;
        y_m = FRAC_ONE - y_c;
        l1_m0_next = $signed({1'b0, y_m}) * p;
        l1_m1_next = $signed({1'b0, y_c}) * s;
        l1_wy_next = 39'(y_c) * 39'(SLOPE_DIFF);
        l1_d_next  = $signed({1'b0, t}) - T_REF;
    end

    // stage 2: blend and temperature product
    logic                l2_vld_reg;
    logic [16:0]         l2_y_reg;
    logic [15:0]         l2_t_reg;
    logic [1:0]          l2_rule_reg;
    logic signed [63:0]  l2_lin_reg, l2_lin_next;
    logic signed [61:0]  l2_dw_reg, l2_dw_next;
    logic [43:0]         w;

    always_comb
    begin
        l2_lin_next = 64'(l1_m0_reg + l1_m1_reg);
        w = W_BASE - {5'b0, l1_wy_reg};
        l2_dw_next = l1_d_reg * $signed({1'b0, w});
    end

    // stage 3: rounded correction
    logic                l3_vld_reg;
    logic [16:0]         l3_y_reg;
    logic [15:0]         l3_t_reg;
    logic [1:0]          l3_rule_reg;
    logic signed [63:0]  l3_lin_reg;
    logic signed [45:0]  l3_corr_reg, l3_corr_next;

    assign l3_corr_next = 46'((l2_dw_reg + 62'sd32768) >>> 16);

    // stage 4: saturate and select by rule
    logic                l4_vld_reg;
    logic [15:0]         l4_t_reg;
    mpe_side_t           l4_side_reg, l4_side_next;
    logic signed [64:0]  diff;

    always_comb
    begin
        diff = 65'(l3_lin_reg) - 65'(l3_corr_reg);
        l4_side_next.y = l3_y_reg;
        l4_side_next.use_visc = 1'b0;
        l4_side_next.value = '0;
        l4_side_next.status = ST_OK;
        unique case (l3_rule_reg)
            RULE_CONST:
            begin
                l4_side_next.value = l3_lin_reg;
            end
            RULE_TEMP:
            begin
                if (diff[64:63] == 2'b01)
                begin
                    l4_side_next.value = 64'h7FFF_FFFF_FFFF_FFFF;
                    l4_side_next.status = ST_SAT;
                end
                else if (diff[64:63] == 2'b10)
                begin
                    l4_side_next.value = 64'h8000_0000_0000_0000;
                    l4_side_next.status = ST_SAT;
                end
                else
                begin
                    l4_side_next.value = diff[63:0];
                end
            end
            RULE_VISC:
            begin
                if (l3_t_reg == '0)
                    l4_side_next.status = ST_ZERO_T;
                else
                    l4_side_next.use_visc = 1'b1;
            end
            RULE_NONE:
            begin
                l4_side_next.status = ST_NO_RULE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_vld_reg <= 1'b0;
            l2_vld_reg <= 1'b0;
            l3_vld_reg <= 1'b0;
            l4_vld_reg <= 1'b0;
        end
        else
        begin
            l1_vld_reg <= in_valid;
            l2_vld_reg <= l1_vld_reg;
            l3_vld_reg <= l2_vld_reg;
            l4_vld_reg <= l3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l1_y_reg    <= y_c;
        l1_t_reg    <= t;
        l1_rule_reg <= rule;
        l1_m0_reg   <= l1_m0_next;
        l1_m1_reg   <= l1_m1_next;
        l1_wy_reg   <= l1_wy_next;
        l1_d_reg    <= l1_d_next;

        l2_y_reg    <= l1_y_reg;
        l2_t_reg    <= l1_t_reg;
        l2_rule_reg <= l1_rule_reg;
        l2_lin_reg  <= l2_lin_next;
        l2_dw_reg   <= l2_dw_next;

        l3_y_reg    <= l2_y_reg;
        l3_t_reg    <= l2_t_reg;
        l3_rule_reg <= l2_rule_reg;
        l3_lin_reg  <= l2_lin_reg;
        l3_corr_reg <= l3_corr_next;

        l4_t_reg    <= l3_t_reg;
        l4_side_reg <= l4_side_next;
    end

    assign out_valid = l4_vld_reg;
    assign out_t     = l4_t_reg;
    assign out_side  = l4_side_reg;

endmodule

>>> src/mpe_recip.sv
module mpe_recip #(
    parameter int TAG_W = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [15:0]              t,
    input  logic [TAG_W-1:0]         in_tag,
    output logic                     out_valid,
    output logic [mpe_pkg::QUO_W-1:0] quo,
    output logic [TAG_W-1:0]         out_tag
);
    import mpe_pkg::*;

    // restoring division of 2^32 by t, DIV_BPS quotient bits per stage
    logic              vld_reg [DIV_STAGES];
    logic [15:0]       rem_reg [DIV_STAGES];
    logic [QUO_W-1:0]  q_reg   [DIV_STAGES];
    logic [15:0]       t_reg   [DIV_STAGES];
    logic [TAG_W-1:0]  tag_reg [DIV_STAGES];

    for (genvar gs = 0; gs < DIV_STAGES; gs++)
    begin : g_stage
        logic              v_in;
        logic [15:0]       r_in;
        logic [QUO_W-1:0]  q_in;
        logic [15:0]       t_in;
        logic [TAG_W-1:0]  g_in;
        logic [15:0]       rem_next;
        logic [QUO_W-1:0]  q_next;

        if (gs == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign q_in = '0;
            assign t_in = t;
            assign g_in = in_tag;
        end
        else
        begin : g_rest
            assign v_in = vld_reg[gs-1];
            assign r_in = rem_reg[gs-1];
            assign q_in = q_reg[gs-1];
            assign t_in = t_reg[gs-1];
            assign g_in = tag_reg[gs-1];
        end

        always_comb
        begin
            logic [16:0]      r2;
            logic [15:0]      r;
            logic [QUO_W-1:0] q;
            r = r_in;
            q = q_in;
            for (int k = 0; k < DIV_BPS; k++)
            begin
                if (gs * DIV_BPS + k < QUO_W)
                begin
                    r2 = {r, (gs * DIV_BPS + k == 0)};
                    if (r2 >= {1'b0, t_in})
                    begin
                        r = 16'(r2 - {1'b0, t_in});
                        q = {q[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = r2[15:0];
                        q = {q[QUO_W-2:0], 1'b0};
                    end
                end
            end
            rem_next = r;
            q_next = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[gs] <= 1'b0;
            else
                vld_reg[gs] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[gs] <= rem_next;
            q_reg[gs]   <= q_next;
            t_reg[gs]   <= t_in;
            tag_reg[gs] <= g_in;
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quo       = q_reg[DIV_STAGES-1];
    assign out_tag   = tag_reg[DIV_STAGES-1];

endmodule

>>> src/mpe_exp2.sv
module mpe_exp2 #(
    parameter int DEPTH = 64,
    parameter int TAG_W = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [39:0] u,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [31:0]        res,
    output logic [TAG_W-1:0]   out_tag
);
    import mpe_pkg::*;

    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int SC_W  = 32 + IDX_W;

    // interpolated table of 2^(i/DEPTH) in Q32
    logic [33:0] e_tab [DEPTH+1];

    for (genvar gi = 0; gi <= DEPTH; gi++)
    begin : g_tab
        localparam logic [63:0] XV = 64'((64'(gi) * LN2_Q32) / 64'(DEPTH));
        localparam logic [63:0] EV = exp_series(XV);
        assign e_tab[gi] = EV[33:0];
    end

    logic              vld_reg [EXP_STAGES];
    logic [TAG_W-1:0]  tag_reg [EXP_STAGES];

    // stage 1: split exponent
    logic [IDX_W-1:0]  x1_idx_reg;
    logic [31:0]       x1_rem_reg;
    logic [1:0]        x1_sh_reg, x1_sh_next;
    logic [SC_W-1:0]   scaled;

    always_comb
    begin
        scaled = SC_W'(u[31:0]) * SC_W'(DEPTH);
        if (u[39])
            x1_sh_next = 2'd0;
        else if (u[39:32] == '0)
            x1_sh_next = 2'd1;
        else
            x1_sh_next = 2'd2;
    end

    // stage 2: table read
    logic [33:0]       x2_lo_reg, x2_hi_reg;
    logic [31:0]       x2_rem_reg;
    logic [1:0]        x2_sh_reg;

    // stage 3: slope product
    logic [65:0]       x3_dp_reg, x3_dp_next;
    logic [33:0]       x3_lo_reg;
    logic [1:0]        x3_sh_reg;

    assign x3_dp_next = 66'(x2_hi_reg - x2_lo_reg) * 66'(x2_rem_reg);

    // stage 4: interpolated value
    logic [33:0]       x4_v_reg, x4_v_next;
    logic [1:0]        x4_sh_reg;

    assign x4_v_next = x3_lo_reg + x3_dp_reg[65:32];

    // stage 5: scale, round, divide by 16
    logic [31:0]       x5_n_reg, x5_n_next;
    logic [35:0]       n_full;

    always_comb
    begin
        n_full = (36'(x4_v_reg) << x4_sh_reg) + 36'd1000;
        x5_n_next = n_full[35:4];
    end

    // stage 6: divide by 125
    logic [64:0]       x6_prod_reg, x6_prod_next;

    assign x6_prod_next = 65'(x5_n_reg) * 65'(M125);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EXP_STAGES; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < EXP_STAGES; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int i = 1; i < EXP_STAGES; i++)
            tag_reg[i] <= tag_reg[i-1];

        x1_idx_reg  <= scaled[SC_W-1:32];
        x1_rem_reg  <= scaled[31:0];
        x1_sh_reg   <= x1_sh_next;

        x2_lo_reg   <= e_tab[x1_idx_reg];
        x2_hi_reg   <= e_tab[x1_idx_reg + IDX_W'(1)];
        x2_rem_reg  <= x1_rem_reg;
        x2_sh_reg   <= x1_sh_reg;

        x3_dp_reg   <= x3_dp_next;
        x3_lo_reg   <= x2_lo_reg;
        x3_sh_reg   <= x2_sh_reg;

        x4_v_reg    <= x4_v_next;
        x4_sh_reg   <= x3_sh_reg;

        x5_n_reg    <= x5_n_next;

        x6_prod_reg <= x6_prod_next;
    end

    assign out_valid = vld_reg[EXP_STAGES-1];
    assign res       = 32'(x6_prod_reg[64:M125_SHIFT]);
    assign out_tag   = tag_reg[EXP_STAGES-1];

endmodule
